// ===== sv/itp_pkg.sv =====
// Shared types, codes and helper functions for the infix to postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  // Sizing defaults
  localparam int ITP_STACK_DEPTH = 32;
  localparam int ITP_QUEUE_DEPTH = 4;

  // ASCII characters of interest
  localparam logic [7:0] CH_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_MUL   = 8'h2A;  // *
  localparam logic [7:0] CH_ADD   = 8'h2B;  // +
  localparam logic [7:0] CH_SUB   = 8'h2D;  // -
  localparam logic [7:0] CH_DIV   = 8'h2F;  // /
  localparam logic [7:0] CH_MOD   = 8'h25;  // %
  localparam logic [7:0] CH_POW   = 8'h5E;  // ^
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Stacked operator codes
  typedef logic [2:0] op_code_t;
  localparam op_code_t OP_OPEN = 3'd0;
  localparam op_code_t OP_ADD  = 3'd1;
  localparam op_code_t OP_SUB  = 3'd2;
  localparam op_code_t OP_MUL  = 3'd3;
  localparam op_code_t OP_DIV  = 3'd4;
  localparam op_code_t OP_MOD  = 3'd5;
  localparam op_code_t OP_POW  = 3'd6;

  // Token classes
  typedef logic [2:0] tok_kind_t;
  localparam tok_kind_t KIND_OTHER = 3'd0;
  localparam tok_kind_t KIND_ALNUM = 3'd1;
  localparam tok_kind_t KIND_OPEN  = 3'd2;
  localparam tok_kind_t KIND_CLOSE = 3'd3;
  localparam tok_kind_t KIND_OPER  = 3'd4;

  // Expression status codes
  typedef logic [1:0] status_t;
  localparam status_t ERR_OK       = 2'd0;
  localparam status_t ERR_OPEN     = 2'd1;
  localparam status_t ERR_CLOSE    = 2'd2;
  localparam status_t ERR_OVERFLOW = 2'd3;

  // Classified input character
  typedef struct packed {
    tok_kind_t  kind;
    op_code_t   code;
    logic [7:0] ch;
    logic       last;
  } token_t;

  // Sort one character into its token class
  function automatic token_t classify(input logic [7:0] ch, input logic last);
    token_t t;
    t.kind = KIND_OTHER;
    t.code = OP_OPEN;
    t.ch   = ch;
    t.last = last;
    if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
        (ch >= 8'h61 && ch <= 8'h7A)) begin
      t.kind = KIND_ALNUM;
    end else begin
      case (ch)
        CH_OPEN:  t.kind = KIND_OPEN;
        CH_CLOSE: t.kind = KIND_CLOSE;
        CH_ADD: begin t.kind = KIND_OPER; t.code = OP_ADD; end
        CH_SUB: begin t.kind = KIND_OPER; t.code = OP_SUB; end
        CH_MUL: begin t.kind = KIND_OPER; t.code = OP_MUL; end
        CH_DIV: begin t.kind = KIND_OPER; t.code = OP_DIV; end
        CH_MOD: begin t.kind = KIND_OPER; t.code = OP_MOD; end
        CH_POW: begin t.kind = KIND_OPER; t.code = OP_POW; end
        default: t.kind = KIND_OTHER;
      endcase
    end
    return t;
  endfunction

  // Precedence rank; an open paren ranks below every operator
  function automatic logic [1:0] rank_of(input op_code_t code);
    logic [1:0] r;
    unique case (code)
      OP_POW:                 r = 2'd3;
      OP_MUL, OP_DIV, OP_MOD: r = 2'd2;
      OP_ADD, OP_SUB:         r = 2'd1;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  // Character emitted for a popped code
  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      OP_OPEN: c = CH_OPEN;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_MOD:  c = CH_MOD;
      OP_POW:  c = CH_POW;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/itp_ifs.sv =====
// Valid/ready channel interfaces for the character input and the postfix output.
`timescale 1ns / 1ps
`default_nettype none

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_last;

  modport source (output valid, output in_char, output is_last, input ready);
  modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, output out_char, output done_res, output status,
                  input ready);
  modport sink   (input valid, input out_char, input done_res, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/itp_front.sv =====
// Front end: accepts input characters, classifies them and registers the token.
`timescale 1ns / 1ps
`default_nettype none

module itp_front
  import itp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  itp_in_if.sink      in_if,
  output token_t      tok,
  output logic        tok_valid,
  input  wire logic   tok_ready
);

  logic   tok_valid_r, tok_valid_nxt;
  token_t tok_r, tok_nxt;
  token_t cls;
  logic   keep;

  // Classify the incoming character
  assign cls  = classify(in_if.in_char, in_if.is_last);
  // Drop ignorable characters unless they end the expression
  assign keep = (cls.kind != KIND_OTHER) || cls.last;

  assign in_if.ready = !tok_valid_r || tok_ready;
  assign tok         = tok_r;
  assign tok_valid   = tok_valid_r;

  // Load the token register on each accepted transaction
  always_comb begin
    tok_valid_nxt = tok_valid_r;
    tok_nxt       = tok_r;
    if (in_if.ready) begin
      tok_valid_nxt = in_if.valid && keep;
      tok_nxt       = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/itp_queue.sv =====
// Short token queue between the front end and the stack engine.
`timescale 1ns / 1ps
`default_nettype none

module itp_queue
  import itp_pkg::*;
#(
  parameter int DEPTH = ITP_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire token_t push_data,
  output logic        full,
  input  wire logic   pop,
  output token_t      pop_data,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t          slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;

  assign full     = (fill_r == CW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed token
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/itp_back.sv =====
// Stack engine: runs the operator stack and drives the registered output.
`timescale 1ns / 1ps
`default_nettype none

module itp_back
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire token_t head,
  input  wire logic   head_empty,
  output logic        head_pop,
  itp_out_if.source   out_if
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLOSE = 2'd1;
  localparam logic [1:0] S_OPER  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  status_t       err_r, err_nxt;
  token_t        cur_r, cur_nxt;

  op_code_t      mem [STACK_DEPTH];
  op_code_t      rd_r;
  logic          we;
  logic [AW-1:0] wa;
  op_code_t      wd;
  logic [CW-1:0] ra_full;
  logic [AW-1:0] ra;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_done_r, out_done_nxt;
  status_t       out_status_r, out_status_nxt;

  logic          out_free;
  logic          has_top;
  logic          emit;
  logic [7:0]    emit_ch;
  logic          emit_done;
  status_t       emit_st;

  assign out_free = !out_valid_r || out_if.ready;
  assign has_top  = (count_r != '0);

  // Main sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    cur_nxt   = cur_r;
    head_pop  = 1'b0;
    we        = 1'b0;
    wa        = count_r[AW-1:0];
    wd        = OP_OPEN;
    emit      = 1'b0;
    emit_ch   = CH_NUL;
    emit_done = 1'b0;
    emit_st   = ERR_OK;

    unique case (state_r)
      S_IDLE: begin
        if (!head_empty) begin
          cur_nxt = head;
          case (head.kind)
            KIND_ALNUM: begin
              if (out_free) begin
                head_pop  = 1'b1;
                emit      = 1'b1;
                emit_ch   = head.ch;
                state_nxt = head.last ? S_FLUSH : S_IDLE;
              end
            end
            KIND_OPEN: begin
              head_pop = 1'b1;
              // push the paren, drop it when full
              if (count_r == CW'(STACK_DEPTH)) begin
                if (err_r == ERR_OK) err_nxt = ERR_OVERFLOW;
              end else begin
                we        = 1'b1;
                wd        = OP_OPEN;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = head.last ? S_FLUSH : S_IDLE;
            end
            KIND_CLOSE: begin
              head_pop  = 1'b1;
              state_nxt = S_CLOSE;
            end
            KIND_OPER: begin
              head_pop  = 1'b1;
              state_nxt = S_OPER;
            end
            default: begin
              head_pop  = 1'b1;
              state_nxt = head.last ? S_FLUSH : S_IDLE;
            end
          endcase
        end
      end

      S_CLOSE: begin
        if (has_top && rd_r != OP_OPEN) begin
          // pop and emit operators above the matching paren
          if (out_free) begin
            emit      = 1'b1;
            emit_ch   = code_char(rd_r);
            count_nxt = count_r - 1'b1;
          end
        end else begin
          if (has_top) begin
            count_nxt = count_r - 1'b1;
          end else if (err_r == ERR_OK) begin
            err_nxt = ERR_CLOSE;
          end
          state_nxt = cur_r.last ? S_FLUSH : S_IDLE;
        end
      end

      S_OPER: begin
        if (has_top && rd_r != OP_OPEN && rank_of(rd_r) >= rank_of(cur_r.code)) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_ch   = code_char(rd_r);
            count_nxt = count_r - 1'b1;
          end
        end else begin
          if (count_r == CW'(STACK_DEPTH)) begin
            if (err_r == ERR_OK) err_nxt = ERR_OVERFLOW;
          end else begin
            we        = 1'b1;
            wd        = cur_r.code;
            count_nxt = count_r + 1'b1;
          end
          state_nxt = cur_r.last ? S_FLUSH : S_IDLE;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (has_top) begin
            // drain the stack, flag leftover parens
            emit_ch   = code_char(rd_r);
            count_nxt = count_r - 1'b1;
            if (rd_r == OP_OPEN && err_r == ERR_OK) err_nxt = ERR_OPEN;
          end else begin
            emit_ch   = CH_NUL;
            emit_done = 1'b1;
            emit_st   = err_r;
            err_nxt   = ERR_OK;
            count_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Read address tracks the top of stack after this cycle
  assign ra_full = count_nxt - 1'b1;
  assign ra      = ra_full[AW-1:0];

  // Stack memory with registered, write-first read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (we && (wa == ra)) begin
      rd_r <= wd;
    end else begin
      rd_r <= mem[ra];
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = emit_ch;
      out_done_nxt   = emit_done;
      out_status_nxt = emit_st;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_char = out_char_r;
  assign out_if.done_res = out_done_r;
  assign out_if.status   = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ERR_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_char_r   <= out_char_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/infix_to_postfix_converter.sv =====
// Top level: shunting-yard infix to postfix converter, front end, queue and stack engine.
// A letter or digit is registered in the front-end token register, a queue slot, then the output register.
// Throughput: the front end takes one character a cycle while the 4-entry queue has room;
// the engine emits each operator popped for an operator or close paren, and on the last
// character flushes each stack entry to the output, then emits the terminator.
// Reset: synchronous, clears control, stack count and error state; stack memory is not
// cleared, so there is no clearing pass and the block is ready the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  itp_in_if.sink    in_if,
  itp_out_if.source out_if
);

  token_t f_tok;
  logic   f_valid;
  logic   q_full;
  logic   q_push;
  token_t q_head;
  logic   q_empty;
  logic   q_pop;

  assign q_push = f_valid && !q_full;

  // Classify characters
  itp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .tok       (f_tok),
    .tok_valid (f_valid),
    .tok_ready (!q_full)
  );

  // Decouple front end from stack engine
  itp_queue #(
    .DEPTH (ITP_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  // Run the operator stack
  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .out_if     (out_if)
  );

`ifndef SYNTH
  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue push while full");

  // Never pop an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  // Terminator carries a null character
  a_term_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.done_res) |-> (out_if.out_char == CH_NUL))
    else $error("terminator with nonzero character");

  // Character results carry no status
  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.done_res) |-> (out_if.status == ERR_OK))
    else $error("status on character result");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the infix to postfix converter.
`timescale 1ns / 1ps

module testbench;
  import itp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       done;
    status_t    st;
  } postfix_t;

  logic clk;
  logic rst_n;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  infix_to_postfix_converter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Shadow state of the converter
  op_code_t op_stack [ITP_STACK_DEPTH];
  int       op_depth;
  status_t  expr_error;
  postfix_t postfix_q [$];

  // Stimulus and checking state
  logic [7:0] expr_q [$];
  int in_idle_pct;
  int out_idle_pct;
  int hold_left;
  int tokens_sent;
  int mismatch_count;
  int stall_cycles;

  localparam logic [7:0] OP_SYMBOL [0:6] = '{CH_OPEN, CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD,
                                             CH_POW};

  always #1 clk = ~clk;

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Map an operator character to its stack code; OP_OPEN means not an operator
  function automatic op_code_t oper_of(input logic [7:0] c);
    op_code_t code;
    code = OP_OPEN;
    if (c == CH_ADD) code = OP_ADD;
    if (c == CH_SUB) code = OP_SUB;
    if (c == CH_MUL) code = OP_MUL;
    if (c == CH_DIV) code = OP_DIV;
    if (c == CH_MOD) code = OP_MOD;
    if (c == CH_POW) code = OP_POW;
    return code;
  endfunction

  function automatic int precedence(input op_code_t code);
    if (code == OP_POW) return 3;
    if (code == OP_MUL || code == OP_DIV || code == OP_MOD) return 2;
    if (code == OP_ADD || code == OP_SUB) return 1;
    return 0;
  endfunction

  function automatic bit is_ignored(input logic [7:0] c);
    return !is_operand(c) && c != CH_OPEN && c != CH_CLOSE && oper_of(c) == OP_OPEN;
  endfunction

  function automatic logic [7:0] rand_operand();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] rand_operator();
    return OP_SYMBOL[$urandom_range(1, 6)];
  endfunction

  function automatic logic [7:0] rand_ignored();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (!is_ignored(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_token();
    case ($urandom_range(0, 4))
      0: return CH_OPEN;
      1: return CH_CLOSE;
      2: return rand_operator();
      3: return rand_ignored();
      default: return rand_operand();
    endcase
  endfunction

  function automatic void note_error(input status_t e);
    if (expr_error == ERR_OK) expr_error = e;
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    postfix_q.push_back('{c, 1'b0, ERR_OK});
  endfunction

  function automatic void pop_emit();
    op_depth--;
    emit_char(OP_SYMBOL[op_stack[op_depth]]);
  endfunction

  function automatic void push_op(input op_code_t code);
    if (op_depth >= ITP_STACK_DEPTH) begin
      note_error(ERR_OVERFLOW);
    end else begin
      op_stack[op_depth] = code;
      op_depth++;
    end
  endfunction

  // Advance the shadow converter by one accepted character
  function automatic void convert_char(input logic [7:0] c, input logic last);
    op_code_t code;
    code = oper_of(c);
    if (is_operand(c)) begin
      emit_char(c);
    end else if (c == CH_OPEN) begin
      push_op(OP_OPEN);
    end else if (c == CH_CLOSE) begin
      while (op_depth > 0 && op_stack[op_depth - 1] != OP_OPEN) pop_emit();
      if (op_depth > 0) op_depth--;
      else note_error(ERR_CLOSE);
    end else if (code != OP_OPEN) begin
      while (op_depth > 0 && precedence(op_stack[op_depth - 1]) >= precedence(code)) pop_emit();
      push_op(code);
    end
    // flush the stack and close the expression
    if (last) begin
      while (op_depth > 0) begin
        if (op_stack[op_depth - 1] == OP_OPEN) note_error(ERR_OPEN);
        pop_emit();
      end
      postfix_q.push_back('{CH_NUL, 1'b1, expr_error});
      expr_error = ERR_OK;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  task automatic check_result();
    postfix_t want;
    if (postfix_q.size() == 0) begin
      report_mismatch("unexpected transaction, out_char", CH_NUL, out_if.out_char);
      return;
    end
    want = postfix_q.pop_front();
    if (out_if.out_char !== want.ch) report_mismatch("out_char", want.ch, out_if.out_char);
    if (out_if.done_res !== want.done)
      report_mismatch("done_res", 8'(want.done), 8'(out_if.done_res));
    if (out_if.status !== want.st) report_mismatch("status", 8'(want.st), 8'(out_if.status));
  endtask

  // Offer one character, hold it until accepted, then predict
  task automatic send_char(input logic [7:0] c, input logic last);
    while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_char <= c;
    in_if.is_last <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    convert_char(c, last);
    if (!is_ignored(c)) tokens_sent++;
  endtask

  task automatic send_string(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last_at_end && i == s.len() - 1);
  endtask

  // Build one expression: mostly well formed, some token soup, some deep nesting
  task automatic build_expression();
    int kind;
    int depth;
    int terms;
    int pos;
    bit want_operand;
    expr_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) expr_q.push_back(rand_token());
    end else if (kind < 12) begin
      depth = $urandom_range(28, 36);
      repeat (depth) expr_q.push_back(CH_OPEN);
      expr_q.push_back(rand_operand());
      repeat ($urandom_range(0, depth)) expr_q.push_back(CH_CLOSE);
    end else begin
      terms = $urandom_range(1, 6);
      depth = 0;
      want_operand = 1'b1;
      while (terms > 0 || want_operand) begin
        if (want_operand) begin
          if (depth < 6 && $urandom_range(0, 3) == 0) begin
            expr_q.push_back(CH_OPEN);
            depth++;
          end else begin
            expr_q.push_back(rand_operand());
            if ($urandom_range(0, 2) == 0) expr_q.push_back(rand_operand());
            want_operand = 1'b0;
            terms--;
          end
        end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
          expr_q.push_back(CH_CLOSE);
          depth--;
        end else begin
          expr_q.push_back(rand_operator());
          want_operand = 1'b1;
        end
      end
      while (depth > 0) begin
        expr_q.push_back(CH_CLOSE);
        depth--;
      end
      // break a few: drop a character or add a stray paren
      if ($urandom_range(0, 9) == 0) begin
        pos = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_q.delete(pos);
          1: expr_q.insert(pos, CH_CLOSE);
          default: expr_q.insert(pos, CH_OPEN);
        endcase
      end
    end
    if (expr_q.size() == 0) expr_q.push_back(rand_operand());
  endtask

  task automatic send_expression();
    for (int i = 0; i < expr_q.size(); i++) begin
      if ($urandom_range(0, 9) == 0) send_char(rand_ignored(), 1'b0);
      send_char(expr_q[i], i == expr_q.size() - 1);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = tokens_sent + count;
    while (tokens_sent < target) begin
      build_expression();
      send_expression();
    end
  endtask

  // Operators, parens, field extremes and ignored bytes
  task automatic test_directed();
    send_string("a+b*c", 1'b1);
    send_string("(0-Z)/9%A", 1'b1);
    send_string("a^b^z", 1'b1);
    send_string(")", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_OPEN, 1'b0);
    send_char(8'h20, 1'b1);
    send_string("a*", 1'b1);
  endtask

  // Overflow the stack with parens, then with an operator push
  task automatic test_stack_overflow();
    repeat (ITP_STACK_DEPTH + 1) send_char(CH_OPEN, 1'b0);
    send_char("z", 1'b0);
    send_char(CH_CLOSE, 1'b1);
    repeat (ITP_STACK_DEPTH) send_char(CH_OPEN, 1'b0);
    send_char(CH_ADD, 1'b0);
    send_char("q", 1'b1);
  endtask

  // Hold off the output so the queue fills and the input stalls
  task automatic test_output_stall();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_left    = HOLD_CYCLES;
    repeat (30) send_char(rand_operand(), 1'b0);
    send_string("+x*y", 1'b1);
  endtask

  task automatic test_random_traffic();
    in_idle_pct  = 13;
    out_idle_pct = 57;
    run_random(80);
    in_idle_pct  = 57;
    out_idle_pct = 13;
    run_random(80);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(80);
  endtask

  // Accept and check results; drive ready
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result();
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_char  = 8'h00;
    in_if.is_last  = 1'b0;
    out_if.ready   = 1'b0;
    op_depth       = 0;
    expr_error     = ERR_OK;
    in_idle_pct    = 13;
    out_idle_pct   = 57;
    hold_left      = 0;
    tokens_sent    = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_stack_overflow();
    test_random_traffic();
    test_output_stall();

    // drain outstanding results, then let the pipeline settle
    in_if.valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && postfix_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== infix_to_postfix_converter.f =====
sv/itp_pkg.sv
sv/itp_ifs.sv
sv/itp_front.sv
sv/itp_queue.sv
sv/itp_back.sv
sv/infix_to_postfix_converter.sv
tb/testbench.sv
